### rtl/khmc_pkg.sv
package khmc_pkg;

  typedef enum logic [2:0] {
    OP_SAMPLE = 3'd0,
    OP_BUTTON = 3'd1,
    OP_BOIL   = 3'd2,
    OP_HOLD   = 3'd3,
    OP_OFF    = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_BOIL = 2'd1,
    MODE_HOLD = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    ST_NONE       = 4'd0,
    ST_BOIL_SET   = 4'd1,
    ST_HOLD_SET   = 4'd2,
    ST_OFF        = 4'd3,
    ST_BOIL_REJ   = 4'd4,
    ST_HOLD_ABOVE = 4'd5,
    ST_BAD_BOIL   = 4'd6,
    ST_BAD_HOLD   = 4'd7,
    ST_BOIL_DONE  = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    REG_SHORT_PRESS = 2'd0,
    REG_HYSTERESIS  = 2'd1,
    REG_BOIL_PRESET = 2'd2,
    REG_HOLD_PRESET = 2'd3
  } reg_idx_e;

  localparam int unsigned InTdataW  = 40;
  localparam int unsigned InTuserW  = 3;
  localparam int unsigned OutTdataW = 24;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [15:0] ShortPressReset = 16'd500;
  localparam logic [6:0]  HysteresisReset = 7'd10;
  localparam logic [6:0]  BoilPresetReset = 7'd100;
  localparam logic [6:0]  HoldPresetReset = 7'd80;
  localparam logic [7:0]  BoilTargetReset = 8'd100;
  localparam logic [7:0]  HoldTargetReset = 8'd80;
  localparam logic [7:0]  TargetMin       = 8'd1;
  localparam logic [7:0]  TargetMax       = 8'd100;
  localparam logic [6:0]  TempMax         = 7'd127;
  // adc_sum / 80 is (adc_sum >> 4) / 5, and x / 5 is (x * 205) >> 10 for x below 1024.
  localparam logic [7:0]  DivFiveRecip    = 8'd205;

  typedef struct packed {
    logic [15:0] short_press_limit_ms;
    logic [6:0]  hysteresis_degrees;
    logic [6:0]  boil_preset;
    logic [6:0]  hold_preset;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [13:0] adc_sum;
    logic [15:0] hold_ms;
    logic [7:0]  setpoint;
  } item_t;

  typedef struct packed {
    mode_e       mode;
    logic        heater;
    logic [6:0]  temp;
    logic [7:0]  boil_target;
    logic [7:0]  hold_target;
  } state_t;

  typedef struct packed {
    logic        heater_on;
    mode_e       mode;
    status_e     status;
    logic [6:0]  temperature;
    logic [7:0]  active_setpoint;
  } result_t;

endpackage

### rtl/khmc_cfg_regs.sv
module khmc_cfg_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  khmc_pkg::reg_idx_e       cfg_index_i,
  input  logic [khmc_pkg::CfgDataW-1:0] cfg_data_i,
  output khmc_pkg::cfg_t           cfg_o
);
  import khmc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SHORT_PRESS: cfg_d.short_press_limit_ms = cfg_data_i[15:0];
        REG_HYSTERESIS:  cfg_d.hysteresis_degrees   = cfg_data_i[6:0];
        REG_BOIL_PRESET: cfg_d.boil_preset          = cfg_data_i[6:0];
        REG_HOLD_PRESET: cfg_d.hold_preset          = cfg_data_i[6:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_press_limit_ms <= ShortPressReset;
      cfg_q.hysteresis_degrees   <= HysteresisReset;
      cfg_q.boil_preset          <= BoilPresetReset;
      cfg_q.hold_preset          <= HoldPresetReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/khmc_step.sv
module khmc_step (
  input  khmc_pkg::cfg_t    cfg_i,
  input  khmc_pkg::state_t  state_i,
  input  khmc_pkg::item_t   item_i,
  output khmc_pkg::state_t  state_o,
  output khmc_pkg::result_t result_o
);
  import khmc_pkg::*;

  logic [9:0]  adc_div16;
  logic [17:0] div_prod;
  logic [7:0]  temp_raw;
  logic [6:0]  temp_sat;
  mode_e       btn_mode;
  logic [8:0]  band_low;

  assign adc_div16 = item_i.adc_sum[13:4];
  assign div_prod  = adc_div16 * DivFiveRecip;
  assign temp_raw  = div_prod[17:10];
  assign temp_sat  = (temp_raw > {1'b0, TempMax}) ? TempMax : temp_raw[6:0];

  // Mode chosen by a button release, before the target check runs.
  always_comb begin
    if (item_i.hold_ms < cfg_i.short_press_limit_ms) begin
      if (state_i.mode != MODE_OFF) begin
        btn_mode = MODE_OFF;
      end else if ({1'b0, state_i.temp} < state_i.boil_target) begin
        btn_mode = MODE_BOIL;
      end else begin
        btn_mode = MODE_OFF;
      end
    end else begin
      btn_mode = (state_i.mode == MODE_OFF) ? MODE_HOLD : MODE_OFF;
    end
  end

  always_comb begin
    state_t  n;
    status_e st;
    logic    do_boil_check;
    logic    do_hold_check;
    logic    do_off;

    n             = state_i;
    st            = ST_NONE;
    do_boil_check = 1'b0;
    do_hold_check = 1'b0;
    do_off        = 1'b0;

    unique case (item_i.opcode)
      OP_SAMPLE: n.temp = temp_sat;
      OP_BUTTON: begin
        n.mode = btn_mode;
        unique case (btn_mode)
          MODE_BOIL: begin
            n.boil_target = {1'b0, cfg_i.boil_preset};
            do_boil_check = 1'b1;
          end
          MODE_HOLD: begin
            n.hold_target = {1'b0, cfg_i.hold_preset};
            do_hold_check = 1'b1;
          end
          default: do_off = 1'b1;
        endcase
      end
      OP_BOIL: begin
        n.boil_target = item_i.setpoint;
        do_boil_check = 1'b1;
      end
      OP_HOLD: begin
        n.hold_target = item_i.setpoint;
        do_hold_check = 1'b1;
      end
      OP_OFF:  do_off = 1'b1;
      default: ;
    endcase

    if (do_boil_check) begin
      if (n.boil_target < TargetMin || n.boil_target > TargetMax) begin
        st = ST_BAD_BOIL;
      end else if ({1'b0, n.temp} > n.boil_target) begin
        st = ST_BOIL_REJ;
      end else begin
        n.mode   = MODE_BOIL;
        n.heater = 1'b1;
        st       = ST_BOIL_SET;
      end
    end

    if (do_hold_check) begin
      if (n.hold_target < TargetMin || n.hold_target > TargetMax) begin
        st = ST_BAD_HOLD;
      end else begin
        n.mode = MODE_HOLD;
        if ({1'b0, n.temp} > n.hold_target) begin
          st = ST_HOLD_ABOVE;
        end else begin
          n.heater = 1'b1;
          st       = ST_HOLD_SET;
        end
      end
    end

    if (do_off) begin
      n.mode   = MODE_OFF;
      n.heater = 1'b0;
      st       = ST_OFF;
    end

    // Regulation runs after every event, on the state the event has left.
    if (n.mode == MODE_BOIL) begin
      if ({1'b0, n.temp} >= n.boil_target) begin
        n.mode   = MODE_OFF;
        n.heater = 1'b0;
        st       = ST_BOIL_DONE;
      end
    end else if (n.mode == MODE_HOLD) begin
      if ({1'b0, n.temp} >= n.hold_target) begin
        n.heater = 1'b0;
      end else if (band_low < {1'b0, n.hold_target}) begin
        n.heater = 1'b1;
      end
    end

    state_o                  = n;
    result_o.heater_on       = n.heater;
    result_o.mode            = n.mode;
    result_o.status          = st;
    result_o.temperature     = n.temp;
    unique case (n.mode)
      MODE_BOIL: result_o.active_setpoint = n.boil_target;
      MODE_HOLD: result_o.active_setpoint = n.hold_target;
      default:   result_o.active_setpoint = 8'd0;
    endcase
  end

  // temp + hysteresis below the target is the same as temp below target minus hysteresis.
  // The temperature used here is the one after this item, which only a sample changes.
  assign band_low = {2'b00, ((item_i.opcode == OP_SAMPLE) ? temp_sat : state_i.temp)}
                    + {2'b00, cfg_i.hysteresis_degrees};

endmodule

### rtl/kettle_heater_mode_controller_core.sv
// Channel  Direction  Signals                                       Contents
// s_axis   in         s_axis_tvalid/tready, tuser[2:0], tdata[39:0]  one event item
// m_axis   out        m_axis_tvalid/tready, tdata[23:0]              one result item per event
// cfg      in         cfg_valid_i/ready_o, cfg_index_i, cfg_data_i   register writes
//
// Each item passes an input register and a result register. Its result is
// presented on m_axis once it moves from the input register into the result
// register, and one item is accepted per cycle while results are taken. Mode
// and targets update at the edge that loads the result register, so
// back-to-back items see each other's effects. A stalled output holds the
// result register and, once it is full, the input register; reset clears the
// control state and loads the preset values.
module kettle_heater_mode_controller_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // adc_sum[13:0], hold_ms[29:14], setpoint[37:30], zeros above
  input  logic [khmc_pkg::InTdataW-1:0]    s_axis_tdata,
  // opcode[2:0]
  input  logic [khmc_pkg::InTuserW-1:0]    s_axis_tuser,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // heater_on[0], mode[2:1], status[6:3], temperature[13:7], active_setpoint[21:14], zeros above
  output logic [khmc_pkg::OutTdataW-1:0]   m_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [1:0]                       cfg_index_i,
  input  logic [khmc_pkg::CfgDataW-1:0]    cfg_data_i
);
  import khmc_pkg::*;

  cfg_t    cfg;
  item_t   in_q;
  logic    in_valid_q;
  result_t out_q, out_d;
  logic    out_valid_q;
  state_t  state_q, state_d;
  logic    advance;

  assign cfg_ready_o = 1'b1;

  khmc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (reg_idx_e'(cfg_index_i)),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  khmc_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (in_q),
    .state_o  (state_d),
    .result_o (out_d)
  );

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q.mode        <= MODE_OFF;
      state_q.heater      <= 1'b0;
      state_q.temp        <= 7'd0;
      state_q.boil_target <= BoilTargetReset;
      state_q.hold_target <= HoldTargetReset;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
        if (in_valid_q) begin
          state_q <= state_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.opcode   <= s_axis_tuser;
      in_q.adc_sum  <= s_axis_tdata[13:0];
      in_q.hold_ms  <= s_axis_tdata[29:14];
      in_q.setpoint <= s_axis_tdata[37:30];
    end
    if (advance && in_valid_q) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.active_setpoint, out_q.temperature, out_q.status,
                          out_q.mode, out_q.heater_on};

endmodule

### sim/tb_kettle_heater_mode_controller_core.sv
`timescale 1ns / 100ps

module tb_kettle_heater_mode_controller_core;
  import khmc_pkg::*;

  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned AdcPerDegree = 80;
  localparam int unsigned PhaseCount   = 11;
  localparam int unsigned PhaseItems   = 105;
  localparam int unsigned ReportMax    = 10;
  // Opcodes beyond the defined set; the block must treat them as no-ops.
  localparam logic [2:0]  OpSpareLo    = 3'd5;
  localparam logic [2:0]  OpSpareHi    = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [13:0] adc;
    logic [15:0] held;
    logic [7:0]  sp;
  } event_t;

  typedef struct {
    event_t  ev;
    bit      typed;
    result_t res;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic [InTdataW-1:0]  s_axis_tdata;
  logic [InTuserW-1:0]  s_axis_tuser;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [1:0]           cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;

  // Predicted controller state and register copies.
  logic [15:0] press_limit;
  logic [6:0]  hyst;
  logic [6:0]  boil_pre;
  logic [6:0]  hold_pre;
  mode_e       cur_mode;
  logic        heater;
  logic [6:0]  cur_temp;
  logic [7:0]  boil_tgt;
  logic [7:0]  hold_tgt;

  result_t     pending_results[$];
  dir_row_t    dir_tab[$];
  int unsigned bad_results = 0;
  int unsigned cycles = 0;
  bit          idle_en = 1'b1;
  int unsigned stall_left = 0;

  always #2 clk_i = ~clk_i;

  kettle_heater_mode_controller_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  function automatic status_e boil_check();
    if (boil_tgt < TargetMin || boil_tgt > TargetMax) return ST_BAD_BOIL;
    if (cur_temp > boil_tgt) return ST_BOIL_REJ;
    cur_mode = MODE_BOIL;
    heater   = 1'b1;
    return ST_BOIL_SET;
  endfunction

  function automatic status_e hold_check();
    if (hold_tgt < TargetMin || hold_tgt > TargetMax) return ST_BAD_HOLD;
    cur_mode = MODE_HOLD;
    if (cur_temp > hold_tgt) return ST_HOLD_ABOVE;
    heater = 1'b1;
    return ST_HOLD_SET;
  endfunction

  function automatic status_e switch_off();
    cur_mode = MODE_OFF;
    heater   = 1'b0;
    return ST_OFF;
  endfunction

  // Applies one event to the predicted state and returns the result it produces.
  function automatic result_t kettle_step(input event_t ev);
    result_t     res;
    status_e     st;
    int unsigned deg;
    st = ST_NONE;
    case (ev.op)
      OP_SAMPLE: begin
        deg      = ev.adc / AdcPerDegree;
        cur_temp = (deg > TempMax) ? TempMax : deg[6:0];
      end
      OP_BUTTON: begin
        if (ev.held < press_limit) begin
          if (cur_mode == MODE_BOIL || cur_mode == MODE_HOLD) cur_mode = MODE_OFF;
          else if (cur_temp < boil_tgt) cur_mode = MODE_BOIL;
        end else begin
          cur_mode = (cur_mode == MODE_OFF) ? MODE_HOLD : MODE_OFF;
        end
        if (cur_mode == MODE_BOIL) begin
          boil_tgt = {1'b0, boil_pre};
          st = boil_check();
        end else if (cur_mode == MODE_HOLD) begin
          hold_tgt = {1'b0, hold_pre};
          st = hold_check();
        end else begin
          st = switch_off();
        end
      end
      OP_BOIL: begin
        boil_tgt = ev.sp;
        st = boil_check();
      end
      OP_HOLD: begin
        hold_tgt = ev.sp;
        st = hold_check();
      end
      OP_OFF: st = switch_off();
      default: ;
    endcase

    if (cur_mode == MODE_BOIL) begin
      if (cur_temp >= boil_tgt) begin
        void'(switch_off());
        st = ST_BOIL_DONE;
      end
    end else if (cur_mode == MODE_HOLD) begin
      if (cur_temp >= hold_tgt) heater = 1'b0;
      else if (int'(cur_temp) < int'(hold_tgt) - int'(hyst)) heater = 1'b1;
    end

    res.heater_on       = heater;
    res.mode            = cur_mode;
    res.status          = st;
    res.temperature     = cur_temp;
    res.active_setpoint = (cur_mode == MODE_BOIL) ? boil_tgt :
                          (cur_mode == MODE_HOLD) ? hold_tgt : 8'd0;
    return res;
  endfunction

  function automatic dir_row_t mk_row(input logic [2:0] op, input logic [13:0] adc,
                                      input logic [15:0] held, input logic [7:0] sp,
                                      input int typed, input int heat, input mode_e md,
                                      input status_e st, input int temp,
                                      input int act);
    dir_row_t r;
    r.ev.op  = op;
    r.ev.adc = adc;
    r.ev.held = held;
    r.ev.sp  = sp;
    r.typed  = (typed != 0);
    r.res.heater_on       = 1'(heat);
    r.res.mode            = md;
    r.res.status          = st;
    r.res.temperature     = 7'(temp);
    r.res.active_setpoint = 8'(act);
    return r;
  endfunction

  // Mostly well-formed events aimed at the current targets, with some noise.
  function automatic event_t rand_event();
    event_t      ev;
    int unsigned pick;
    int unsigned aim;
    int          val;
    ev.op   = OP_OFF;
    ev.adc  = 14'($urandom_range(0, 16383));
    ev.held = 16'($urandom_range(0, 65535));
    ev.sp   = 8'($urandom_range(0, 255));
    pick    = $urandom_range(0, 99);
    if (pick < 45) begin
      ev.op = OP_SAMPLE;
      if ($urandom_range(0, 4) != 0) begin
        aim = (cur_mode == MODE_HOLD) ? hold_tgt :
              (cur_mode == MODE_BOIL) ? boil_tgt : $urandom_range(0, 110);
        val = int'(aim) + int'($urandom_range(0, 25)) - 20;
        if (val < 0) val = 0;
        if (val > 127) val = 127;
        ev.adc = 14'(val * AdcPerDegree + int'($urandom_range(0, 79)));
      end
    end else if (pick < 65) begin
      ev.op = OP_BUTTON;
      case ($urandom_range(0, 3))
        0, 1: begin
          val = int'(press_limit) + int'($urandom_range(0, 4)) - 2;
          if (val < 0) val = 0;
          if (val > 65535) val = 65535;
          ev.held = 16'(val);
        end
        2: ev.held = 16'($urandom_range(0, press_limit));
        default: ;
      endcase
    end else if (pick < 77) begin
      ev.op = OP_BOIL;
      if ($urandom_range(0, 4) != 0) ev.sp = 8'($urandom_range(1, 100));
    end else if (pick < 89) begin
      ev.op = OP_HOLD;
      if ($urandom_range(0, 4) != 0) ev.sp = 8'($urandom_range(1, 100));
    end else if (pick >= 95) begin
      ev.op = 3'($urandom_range(OpSpareLo, OpSpareHi));
    end
    return ev;
  endfunction

  task automatic send_event(input event_t ev, input bit typed, input result_t typed_res);
    int unsigned gap;
    result_t     res;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tdata  = {2'd0, ev.sp, ev.held, ev.adc};
    s_axis_tuser  = ev.op;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    res = kettle_step(ev);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_index_i = idx;
    cfg_data_i  = val;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_SHORT_PRESS: press_limit = val;
      REG_HYSTERESIS:  hyst        = val[6:0];
      REG_BOIL_PRESET: boil_pre    = val[6:0];
      REG_HOLD_PRESET: hold_pre    = val[6:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [6:0] rand_preset();
    return ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                       : 7'($urandom_range(1, 100));
  endfunction

  // Receiver stalls in bursts; none once idling is switched off.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni || !idle_en) begin
        m_axis_tready = rst_ni;
        stall_left    = 0;
      end else if (stall_left != 0) begin
        stall_left--;
        m_axis_tready = 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left    = $urandom_range(1, 12) - 1;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t     want;
    logic        got_heat;
    logic [1:0]  got_mode;
    logic [3:0]  got_st;
    logic [6:0]  got_temp;
    logic [7:0]  got_act;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_heat = m_axis_tdata[0];
      got_mode = m_axis_tdata[2:1];
      got_st   = m_axis_tdata[6:3];
      got_temp = m_axis_tdata[13:7];
      got_act  = m_axis_tdata[21:14];
      if (pending_results.size() == 0) begin
        bad_results++;
        if (bad_results <= ReportMax)
          $display("%0t: result item with nothing outstanding: %h", $realtime, m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got_heat !== want.heater_on || got_mode !== want.mode ||
            got_st !== want.status || got_temp !== want.temperature ||
            got_act !== want.active_setpoint) begin
          bad_results++;
          if (bad_results <= ReportMax)
            $display({"%0t: heater/mode/status/temp/setpoint exp %0d/%0d/%0d/%0d/%0d",
                      " got %0d/%0d/%0d/%0d/%0d"},
                     $realtime, want.heater_on, want.mode, want.status, want.temperature,
                     want.active_setpoint, got_heat, got_mode, got_st, got_temp, got_act);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_kettle_heater_mode_controller_core: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    event_t  ev;
    result_t none;
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tvalid = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_SHORT_PRESS;
    cfg_data_i    = '0;
    none          = '0;

    press_limit = ShortPressReset;
    hyst        = HysteresisReset;
    boil_pre    = BoilPresetReset;
    hold_pre    = HoldPresetReset;
    cur_mode    = MODE_OFF;
    heater      = 1'b0;
    cur_temp    = '0;
    boil_tgt    = BoilTargetReset;
    hold_tgt    = HoldTargetReset;

    // Rows marked 1 carry a hand-worked result; the rest go through the predictor.
    dir_tab.push_back(mk_row(OP_SAMPLE, 14'd0,     16'd0, 8'd0,   1, 0, MODE_OFF,  ST_NONE, 0, 0));
    dir_tab.push_back(mk_row(OP_OFF,    14'd0,     16'd0, 8'd0,   1, 0, MODE_OFF,  ST_OFF, 0, 0));
    dir_tab.push_back(mk_row(OP_BOIL,   14'd0,     16'd0, 8'd0,   1, 0, MODE_OFF,  ST_BAD_BOIL, 0, 0));
    dir_tab.push_back(mk_row(OP_BOIL,   14'd0,     16'd0, 8'd255, 1, 0, MODE_OFF,  ST_BAD_BOIL, 0, 0));
    dir_tab.push_back(mk_row(OP_BOIL,   14'd0,     16'd0, 8'd101, 1, 0, MODE_OFF,  ST_BAD_BOIL, 0, 0));
    dir_tab.push_back(mk_row(OP_HOLD,   14'd0,     16'd0, 8'd0,   1, 0, MODE_OFF,  ST_BAD_HOLD, 0, 0));
    dir_tab.push_back(mk_row(OP_HOLD,   14'd0,     16'd0, 8'd255, 1, 0, MODE_OFF,  ST_BAD_HOLD, 0, 0));
    dir_tab.push_back(mk_row(OP_BOIL,   14'd0,     16'd0, 8'd100, 1, 1, MODE_BOIL,
                             ST_BOIL_SET, 0, 100));
    dir_tab.push_back(mk_row(OP_SAMPLE, 14'd16383, 16'd0, 8'd0,   1, 0, MODE_OFF,
                             ST_BOIL_DONE, 127, 0));
    dir_tab.push_back(mk_row(OP_BOIL,   14'd0,     16'd0, 8'd100, 1, 0, MODE_OFF,
                             ST_BOIL_REJ, 127, 0));
    dir_tab.push_back(mk_row(OP_HOLD,   14'd0,     16'd0, 8'd1,   1, 0, MODE_HOLD,
                             ST_HOLD_ABOVE, 127, 1));
    dir_tab.push_back(mk_row(OP_SAMPLE, 14'd10230, 16'd0, 8'd0,   0, 0, MODE_OFF,  ST_NONE, 0, 0));
    dir_tab.push_back(mk_row(OP_SAMPLE, 14'd4000,  16'd0, 8'd0,   0, 0, MODE_OFF,  ST_NONE, 0, 0));
    dir_tab.push_back(mk_row(OP_HOLD,   14'd0,     16'd0, 8'd100, 0, 0, MODE_OFF,  ST_NONE, 0, 0));
    dir_tab.push_back(mk_row(OP_SAMPLE, 14'd7999,  16'd0, 8'd0,   0, 0, MODE_OFF,  ST_NONE, 0, 0));
    dir_tab.push_back(mk_row(OP_SAMPLE, 14'd8000,  16'd0, 8'd0,   0, 0, MODE_OFF,  ST_NONE, 0, 0));
    dir_tab.push_back(mk_row(OP_SAMPLE, 14'd7200,  16'd0, 8'd0,   0, 0, MODE_OFF,  ST_NONE, 0, 0));
    dir_tab.push_back(mk_row(OP_SAMPLE, 14'd7119,  16'd0, 8'd0,   0, 0, MODE_OFF,  ST_NONE, 0, 0));
    dir_tab.push_back(mk_row(OP_BUTTON, 14'd0,     16'd0, 8'd0,   0, 0, MODE_OFF,  ST_NONE, 0, 0));
    dir_tab.push_back(mk_row(OP_BUTTON, 14'd0,   16'd499, 8'd0,   0, 0, MODE_OFF,  ST_NONE, 0, 0));
    dir_tab.push_back(mk_row(OP_BUTTON, 14'd0,   16'd500, 8'd0,   0, 0, MODE_OFF,  ST_NONE, 0, 0));
    dir_tab.push_back(mk_row(OP_BUTTON, 14'd0, 16'd65535, 8'd0,   0, 0, MODE_OFF,  ST_NONE, 0, 0));
    dir_tab.push_back(mk_row(OP_BOIL,   14'd0,     16'd0, 8'd1,   0, 0, MODE_OFF,  ST_NONE, 0, 0));
    dir_tab.push_back(mk_row(OpSpareLo, 14'd0,     16'd0, 8'd0,   0, 0, MODE_OFF,  ST_NONE, 0, 0));
    dir_tab.push_back(mk_row(OpSpareHi, 14'd0,     16'd0, 8'd0,   0, 0, MODE_OFF,  ST_NONE, 0, 0));
    dir_tab.push_back(mk_row(OP_OFF,    14'd0,     16'd0, 8'd0,   0, 0, MODE_OFF,  ST_NONE, 0, 0));
    dir_tab.push_back(mk_row(OP_SAMPLE, 14'd16383, 16'd0, 8'd0,   0, 0, MODE_OFF,  ST_NONE, 0, 0));
    dir_tab.push_back(mk_row(OP_BUTTON, 14'd0,     16'd0, 8'd0,   0, 0, MODE_OFF,  ST_NONE, 0, 0));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i]) send_event(dir_tab[i].ev, dir_tab[i].typed, dir_tab[i].res);

    for (int unsigned ph = 0; ph < PhaseCount; ph++) begin
      drain();
      idle_en = (ph != PhaseCount - 1) && (ph % 4 != 3);
      // The first phases pin the registers at their extremes or reset values.
      case (ph)
        0: begin
          write_reg(REG_SHORT_PRESS, 16'd0);
          write_reg(REG_HYSTERESIS,  16'd0);
          write_reg(REG_BOIL_PRESET, 16'd1);
          write_reg(REG_HOLD_PRESET, 16'd1);
        end
        1: begin
          write_reg(REG_SHORT_PRESS, 16'd65535);
          write_reg(REG_HYSTERESIS,  16'd127);
          write_reg(REG_BOIL_PRESET, 16'd100);
          write_reg(REG_HOLD_PRESET, 16'd100);
        end
        2: begin
          write_reg(REG_SHORT_PRESS, 16'd1);
          write_reg(REG_HYSTERESIS,  16'd100);
          write_reg(REG_BOIL_PRESET, 16'd0);
          write_reg(REG_HOLD_PRESET, 16'd0);
        end
        3: begin
          write_reg(REG_SHORT_PRESS, ShortPressReset);
          write_reg(REG_HYSTERESIS,  16'd10);
          write_reg(REG_BOIL_PRESET, 16'd127);
          write_reg(REG_HOLD_PRESET, 16'd127);
        end
        default: begin
          write_reg(REG_SHORT_PRESS, ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                                 : 16'($urandom_range(0, 2000)));
          write_reg(REG_HYSTERESIS,  {9'd0, 7'($urandom_range(0, 127))});
          write_reg(REG_BOIL_PRESET, {9'd0, rand_preset()});
          write_reg(REG_HOLD_PRESET, {9'd0, rand_preset()});
        end
      endcase
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        ev = rand_event();
        send_event(ev, 1'b0, none);
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (bad_results == 0) begin
      $display("tb_kettle_heater_mode_controller_core: PASS");
    end else begin
      $display("tb_kettle_heater_mode_controller_core: FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/khmc_pkg.sv
rtl/khmc_cfg_regs.sv
rtl/khmc_step.sv
rtl/kettle_heater_mode_controller_core.sv
sim/tb_kettle_heater_mode_controller_core.sv
